FILE: hw/rtl/rvdec_pkg.sv
package rvdec_pkg;

    // Major opcodes (instruction bits 6..0)
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 values, ALU group (register and immediate forms)
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 values, memory access
    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    // funct3 values, branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct3 value for jalr
    localparam logic [2:0] F3_JALR = 3'd0;

    typedef logic [5:0] mnemonic_t;
    typedef logic [2:0] format_t;

    // Dense mnemonic codes
    localparam mnemonic_t MN_UNKNOWN = 6'd0;
    localparam mnemonic_t MN_LUI     = 6'd1;
    localparam mnemonic_t MN_AUIPC   = 6'd2;
    localparam mnemonic_t MN_ADD     = 6'd3;
    localparam mnemonic_t MN_SUB     = 6'd4;
    localparam mnemonic_t MN_SLL     = 6'd5;
    localparam mnemonic_t MN_SLT     = 6'd6;
    localparam mnemonic_t MN_SLTU    = 6'd7;
    localparam mnemonic_t MN_XOR     = 6'd8;
    localparam mnemonic_t MN_SRL     = 6'd9;
    localparam mnemonic_t MN_SRA     = 6'd10;
    localparam mnemonic_t MN_OR      = 6'd11;
    localparam mnemonic_t MN_AND     = 6'd12;
    localparam mnemonic_t MN_ADDI    = 6'd13;
    localparam mnemonic_t MN_SLTI    = 6'd14;
    localparam mnemonic_t MN_SLTIU   = 6'd15;
    localparam mnemonic_t MN_XORI    = 6'd16;
    localparam mnemonic_t MN_ORI     = 6'd17;
    localparam mnemonic_t MN_ANDI    = 6'd18;
    localparam mnemonic_t MN_SLLI    = 6'd19;
    localparam mnemonic_t MN_SRLI    = 6'd20;
    localparam mnemonic_t MN_SRAI    = 6'd21;
    localparam mnemonic_t MN_LB      = 6'd22;
    localparam mnemonic_t MN_LH      = 6'd23;
    localparam mnemonic_t MN_LW      = 6'd24;
    localparam mnemonic_t MN_LBU     = 6'd25;
    localparam mnemonic_t MN_LHU     = 6'd26;
    localparam mnemonic_t MN_SB      = 6'd27;
    localparam mnemonic_t MN_SH      = 6'd28;
    localparam mnemonic_t MN_SW      = 6'd29;
    localparam mnemonic_t MN_BEQ     = 6'd30;
    localparam mnemonic_t MN_BNE     = 6'd31;
    localparam mnemonic_t MN_BLT     = 6'd32;
    localparam mnemonic_t MN_BGE     = 6'd33;
    localparam mnemonic_t MN_BLTU    = 6'd34;
    localparam mnemonic_t MN_BGEU    = 6'd35;
    localparam mnemonic_t MN_JAL     = 6'd36;
    localparam mnemonic_t MN_JALR    = 6'd37;

    // Format codes
    localparam format_t FMT_UNKNOWN = 3'd0;
    localparam format_t FMT_R       = 3'd1;
    localparam format_t FMT_I_ARITH = 3'd2;
    localparam format_t FMT_I_LOAD  = 3'd3;
    localparam format_t FMT_S       = 3'd4;
    localparam format_t FMT_B       = 3'd5;
    localparam format_t FMT_U       = 3'd6;
    localparam format_t FMT_J       = 3'd7;

    // Decode result passed from the decode logic to the result register
    typedef struct packed {
        mnemonic_t   mnemonic;
        format_t     format;
        logic [31:0] immediate;
    } dec_result_t;

endpackage

FILE: hw/rtl/rvdec_core.sv
module rvdec_core (
    input  logic [31:0]                instruction,
    output rvdec_pkg::dec_result_t     result
);

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] imm_shamt;

    assign opcode = instruction[6:0];
    assign funct3 = instruction[14:12];
    assign funct7 = instruction[31:25];

    // Gather the immediate of every format
    assign imm_i     = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s     = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b     = {{19{instruction[31]}}, instruction[31], instruction[7],
                        instruction[30:25], instruction[11:8], 1'b0};
    assign imm_u     = {instruction[31:12], 12'h000};
    assign imm_j     = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                        instruction[20], instruction[30:21], 1'b0};
    assign imm_shamt = {27'd0, instruction[24:20]};

    // Match opcode, funct3 and funct7; anything unlisted stays unknown
    always_comb
    begin
        result.mnemonic  = rvdec_pkg::MN_UNKNOWN;
        result.format    = rvdec_pkg::FMT_UNKNOWN;
        result.immediate = 32'd0;
        unique case (opcode)
            rvdec_pkg::OPC_LUI:
            begin
                result.mnemonic  = rvdec_pkg::MN_LUI;
                result.format    = rvdec_pkg::FMT_U;
                result.immediate = imm_u;
            end
            rvdec_pkg::OPC_AUIPC:
            begin
                result.mnemonic  = rvdec_pkg::MN_AUIPC;
                result.format    = rvdec_pkg::FMT_U;
                result.immediate = imm_u;
            end
            rvdec_pkg::OPC_OP:
            begin
                if (funct7 == rvdec_pkg::F7_BASE)
                begin
                    result.format = rvdec_pkg::FMT_R;
                    unique case (funct3)
                        rvdec_pkg::F3_ADD:  result.mnemonic = rvdec_pkg::MN_ADD;
                        rvdec_pkg::F3_SLL:  result.mnemonic = rvdec_pkg::MN_SLL;
                        rvdec_pkg::F3_SLT:  result.mnemonic = rvdec_pkg::MN_SLT;
                        rvdec_pkg::F3_SLTU: result.mnemonic = rvdec_pkg::MN_SLTU;
                        rvdec_pkg::F3_XOR:  result.mnemonic = rvdec_pkg::MN_XOR;
                        rvdec_pkg::F3_SR:   result.mnemonic = rvdec_pkg::MN_SRL;
                        rvdec_pkg::F3_OR:   result.mnemonic = rvdec_pkg::MN_OR;
                        default:            result.mnemonic = rvdec_pkg::MN_AND;
                    endcase
                end
                else if (funct7 == rvdec_pkg::F7_ALT && funct3 == rvdec_pkg::F3_ADD)
                begin
                    result.mnemonic = rvdec_pkg::MN_SUB;
                    result.format   = rvdec_pkg::FMT_R;
                end
                else if (funct7 == rvdec_pkg::F7_ALT && funct3 == rvdec_pkg::F3_SR)
                begin
                    result.mnemonic = rvdec_pkg::MN_SRA;
                    result.format   = rvdec_pkg::FMT_R;
                end
            end
            rvdec_pkg::OPC_OP_IMM:
            begin
                result.format    = rvdec_pkg::FMT_I_ARITH;
                result.immediate = imm_i;
                unique case (funct3)
                    rvdec_pkg::F3_ADD:  result.mnemonic = rvdec_pkg::MN_ADDI;
                    rvdec_pkg::F3_SLT:  result.mnemonic = rvdec_pkg::MN_SLTI;
                    rvdec_pkg::F3_SLTU: result.mnemonic = rvdec_pkg::MN_SLTIU;
                    rvdec_pkg::F3_XOR:  result.mnemonic = rvdec_pkg::MN_XORI;
                    rvdec_pkg::F3_OR:   result.mnemonic = rvdec_pkg::MN_ORI;
                    rvdec_pkg::F3_AND:  result.mnemonic = rvdec_pkg::MN_ANDI;
                    rvdec_pkg::F3_SLL:
                    begin
                        result.immediate = imm_shamt;
                        if (funct7 == rvdec_pkg::F7_BASE)
                            result.mnemonic = rvdec_pkg::MN_SLLI;
                    end
                    default:
                    begin
                        result.immediate = imm_shamt;
                        if (funct7 == rvdec_pkg::F7_BASE)
                            result.mnemonic = rvdec_pkg::MN_SRLI;
                        else if (funct7 == rvdec_pkg::F7_ALT)
                            result.mnemonic = rvdec_pkg::MN_SRAI;
                    end
                endcase
                // Drop format and immediate for a bad shift encoding
                if (result.mnemonic == rvdec_pkg::MN_UNKNOWN)
                begin
                    result.format    = rvdec_pkg::FMT_UNKNOWN;
                    result.immediate = 32'd0;
                end
            end
            rvdec_pkg::OPC_LOAD:
            begin
                result.format    = rvdec_pkg::FMT_I_LOAD;
                result.immediate = imm_i;
                unique case (funct3)
                    rvdec_pkg::F3_B:  result.mnemonic = rvdec_pkg::MN_LB;
                    rvdec_pkg::F3_H:  result.mnemonic = rvdec_pkg::MN_LH;
                    rvdec_pkg::F3_W:  result.mnemonic = rvdec_pkg::MN_LW;
                    rvdec_pkg::F3_BU: result.mnemonic = rvdec_pkg::MN_LBU;
                    rvdec_pkg::F3_HU: result.mnemonic = rvdec_pkg::MN_LHU;
                    default:
                    begin
                        result.format    = rvdec_pkg::FMT_UNKNOWN;
                        result.immediate = 32'd0;
                    end
                endcase
            end
            rvdec_pkg::OPC_STORE:
            begin
                result.format    = rvdec_pkg::FMT_S;
                result.immediate = imm_s;
                unique case (funct3)
                    rvdec_pkg::F3_B: result.mnemonic = rvdec_pkg::MN_SB;
                    rvdec_pkg::F3_H: result.mnemonic = rvdec_pkg::MN_SH;
                    rvdec_pkg::F3_W: result.mnemonic = rvdec_pkg::MN_SW;
                    default:
                    begin
                        result.format    = rvdec_pkg::FMT_UNKNOWN;
                        result.immediate = 32'd0;
                    end
                endcase
            end
            rvdec_pkg::OPC_BRANCH:
            begin
                result.format    = rvdec_pkg::FMT_B;
                result.immediate = imm_b;
                unique case (funct3)
                    rvdec_pkg::F3_BEQ:  result.mnemonic = rvdec_pkg::MN_BEQ;
                    rvdec_pkg::F3_BNE:  result.mnemonic = rvdec_pkg::MN_BNE;
                    rvdec_pkg::F3_BLT:  result.mnemonic = rvdec_pkg::MN_BLT;
                    rvdec_pkg::F3_BGE:  result.mnemonic = rvdec_pkg::MN_BGE;
                    rvdec_pkg::F3_BLTU: result.mnemonic = rvdec_pkg::MN_BLTU;
                    rvdec_pkg::F3_BGEU: result.mnemonic = rvdec_pkg::MN_BGEU;
                    default:
                    begin
                        result.format    = rvdec_pkg::FMT_UNKNOWN;
                        result.immediate = 32'd0;
                    end
                endcase
            end
            rvdec_pkg::OPC_JAL:
            begin
                result.mnemonic  = rvdec_pkg::MN_JAL;
                result.format    = rvdec_pkg::FMT_J;
                result.immediate = imm_j;
            end
            rvdec_pkg::OPC_JALR:
            begin
                if (funct3 == rvdec_pkg::F3_JALR)
                begin
                    result.mnemonic  = rvdec_pkg::MN_JALR;
                    result.format    = rvdec_pkg::FMT_I_LOAD;
                    result.immediate = imm_i;
                end
            end
            default:
            begin
                result.mnemonic  = rvdec_pkg::MN_UNKNOWN;
                result.format    = rvdec_pkg::FMT_UNKNOWN;
                result.immediate = 32'd0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rv32i_instruction_decoder.sv
// RV32I instruction decoder. Each accepted instruction word yields one result item:
// a mnemonic code (0 for an unrecognized word), a format code, the raw rd/rs1/rs2
// fields and the immediate of the recognized format, sign-extended but for shifts.
// The block has an input register and a result register with the decode logic
// between them. A word waits in the input register until the result register loads
// its item. One item is accepted every cycle while the output side is not stalled.
// An output stall reaches in_stall in the same cycle once both registers are full.
module rv32i_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  mnemonic,
    output logic [2:0]  format,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src1_reg,
    output logic [4:0]  src2_reg,
    output logic [31:0] immediate
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [31:0]            in_instr_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rvdec_pkg::dec_result_t out_result_reg;
    logic [14:0]            out_regs_reg;
    rvdec_pkg::dec_result_t dec_result;
    logic                   out_load;
    logic                   in_load;

    // Advance the result register when it is empty or being taken
    assign out_load = !out_valid_reg || !out_stall;
    // Advance the input register when it is empty or moving forward
    assign in_load  = !in_valid_reg || out_load;
    assign in_stall = !in_load;

    rvdec_core u_core (
        .instruction (in_instr_reg),
        .result      (dec_result)
    );

    // Next valid flags of both stages
    always_comb
    begin
        in_valid_next  = in_load ? in_valid : in_valid_reg;
        out_valid_next = out_load ? in_valid_reg : out_valid_reg;
    end

    // Clear valid flags on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the instruction word and the decoded item
    always_ff @(posedge clk)
    begin
        if (in_load)
            in_instr_reg <= instruction;
        if (out_load)
        begin
            out_result_reg <= dec_result;
            out_regs_reg   <= {in_instr_reg[11:7], in_instr_reg[19:15], in_instr_reg[24:20]};
        end
    end

    assign out_valid = out_valid_reg;
    assign mnemonic  = out_result_reg.mnemonic;
    assign format    = out_result_reg.format;
    assign immediate = out_result_reg.immediate;
    assign dest_reg  = out_regs_reg[14:10];
    assign src1_reg  = out_regs_reg[9:5];
    assign src2_reg  = out_regs_reg[4:0];

    // Unknown mnemonic and unknown format always go together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((mnemonic == rvdec_pkg::MN_UNKNOWN) ==
                       (format == rvdec_pkg::FMT_UNKNOWN)))
        else $error("mnemonic and format disagree on unknown");

    // Unknown and R-type items carry a zero immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (format == rvdec_pkg::FMT_UNKNOWN || format == rvdec_pkg::FMT_R)
        |-> immediate == 32'd0)
        else $error("nonzero immediate on unknown or R-type item");

    // U-type immediates keep the low 12 bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format == rvdec_pkg::FMT_U |-> immediate[11:0] == 12'd0)
        else $error("U-type immediate has low bits set");

    // Input stall only while both stages hold an item and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a full pipeline");

    // A stalled input stage moves its item forward once the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_stall |=> out_valid)
        else $error("pending item lost when the result was taken");

endmodule

FILE: tb/rv32i_decoder_checker.sv
module rv32i_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] instruction,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  mnemonic,
    input  logic [2:0]  format,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src1_reg,
    input  logic [4:0]  src2_reg,
    input  logic [31:0] immediate,

    output int          error_count,
    output int          pending,
    output int          results_checked,
    output int          kinds_seen,
    output int          unknown_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rvdec_pkg::mnemonic_t mn;
        rvdec_pkg::format_t   fmt;
        logic [4:0]           rd;
        logic [4:0]           rs1;
        logic [4:0]           rs2;
        logic [31:0]          imm;
    } decoded_t;

    decoded_t    expected_q[$];
    logic [37:0] kinds_hit;

    // Decode one word: mnemonic, format, raw register fields, format immediate
    function automatic decoded_t decode_word(logic [31:0] w);
        decoded_t    d;
        logic [6:0]  opc;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] imm_i;
        logic [12:0] boff;
        logic [20:0] joff;

        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        boff  = {w[31], w[7], w[30:25], w[11:8], 1'b0};
        joff  = {w[31], w[19:12], w[20], w[30:21], 1'b0};

        d.mn  = rvdec_pkg::MN_UNKNOWN;
        d.fmt = rvdec_pkg::FMT_UNKNOWN;
        d.imm = '0;
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];

        case (opc)
            rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC:
            begin
                d.mn  = (opc == rvdec_pkg::OPC_LUI) ? rvdec_pkg::MN_LUI
                                                    : rvdec_pkg::MN_AUIPC;
                d.fmt = rvdec_pkg::FMT_U;
                d.imm = {w[31:12], 12'b0};
            end
            rvdec_pkg::OPC_OP:
            begin
                if (f7 == rvdec_pkg::F7_BASE)
                begin
                    case (f3)
                        rvdec_pkg::F3_ADD:  d.mn = rvdec_pkg::MN_ADD;
                        rvdec_pkg::F3_SLL:  d.mn = rvdec_pkg::MN_SLL;
                        rvdec_pkg::F3_SLT:  d.mn = rvdec_pkg::MN_SLT;
                        rvdec_pkg::F3_SLTU: d.mn = rvdec_pkg::MN_SLTU;
                        rvdec_pkg::F3_XOR:  d.mn = rvdec_pkg::MN_XOR;
                        rvdec_pkg::F3_SR:   d.mn = rvdec_pkg::MN_SRL;
                        rvdec_pkg::F3_OR:   d.mn = rvdec_pkg::MN_OR;
                        default:            d.mn = rvdec_pkg::MN_AND;
                    endcase
                end
                else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ADD)
                    d.mn = rvdec_pkg::MN_SUB;
                else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_SR)
                    d.mn = rvdec_pkg::MN_SRA;
                if (d.mn != rvdec_pkg::MN_UNKNOWN)
                    d.fmt = rvdec_pkg::FMT_R;
            end
            rvdec_pkg::OPC_OP_IMM:
            begin
                d.imm = imm_i;
                case (f3)
                    rvdec_pkg::F3_ADD:  d.mn = rvdec_pkg::MN_ADDI;
                    rvdec_pkg::F3_SLT:  d.mn = rvdec_pkg::MN_SLTI;
                    rvdec_pkg::F3_SLTU: d.mn = rvdec_pkg::MN_SLTIU;
                    rvdec_pkg::F3_XOR:  d.mn = rvdec_pkg::MN_XORI;
                    rvdec_pkg::F3_OR:   d.mn = rvdec_pkg::MN_ORI;
                    rvdec_pkg::F3_AND:  d.mn = rvdec_pkg::MN_ANDI;
                    rvdec_pkg::F3_SLL:
                    begin
                        if (f7 == rvdec_pkg::F7_BASE)
                            d.mn = rvdec_pkg::MN_SLLI;
                    end
                    default:
                    begin
                        if (f7 == rvdec_pkg::F7_BASE)
                            d.mn = rvdec_pkg::MN_SRLI;
                        else if (f7 == rvdec_pkg::F7_ALT)
                            d.mn = rvdec_pkg::MN_SRAI;
                    end
                endcase
                // shifts carry only the 5-bit shift amount
                if (f3 == rvdec_pkg::F3_SLL || f3 == rvdec_pkg::F3_SR)
                    d.imm = {27'b0, w[24:20]};
                if (d.mn != rvdec_pkg::MN_UNKNOWN)
                    d.fmt = rvdec_pkg::FMT_I_ARITH;
                else
                    d.imm = '0;
            end
            rvdec_pkg::OPC_LOAD:
            begin
                case (f3)
                    rvdec_pkg::F3_B:  d.mn = rvdec_pkg::MN_LB;
                    rvdec_pkg::F3_H:  d.mn = rvdec_pkg::MN_LH;
                    rvdec_pkg::F3_W:  d.mn = rvdec_pkg::MN_LW;
                    rvdec_pkg::F3_BU: d.mn = rvdec_pkg::MN_LBU;
                    rvdec_pkg::F3_HU: d.mn = rvdec_pkg::MN_LHU;
                    default:          d.mn = rvdec_pkg::MN_UNKNOWN;
                endcase
                if (d.mn != rvdec_pkg::MN_UNKNOWN)
                begin
                    d.fmt = rvdec_pkg::FMT_I_LOAD;
                    d.imm = imm_i;
                end
            end
            rvdec_pkg::OPC_STORE:
            begin
                case (f3)
                    rvdec_pkg::F3_B: d.mn = rvdec_pkg::MN_SB;
                    rvdec_pkg::F3_H: d.mn = rvdec_pkg::MN_SH;
                    rvdec_pkg::F3_W: d.mn = rvdec_pkg::MN_SW;
                    default:         d.mn = rvdec_pkg::MN_UNKNOWN;
                endcase
                if (d.mn != rvdec_pkg::MN_UNKNOWN)
                begin
                    d.fmt = rvdec_pkg::FMT_S;
                    d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                end
            end
            rvdec_pkg::OPC_BRANCH:
            begin
                case (f3)
                    rvdec_pkg::F3_BEQ:  d.mn = rvdec_pkg::MN_BEQ;
                    rvdec_pkg::F3_BNE:  d.mn = rvdec_pkg::MN_BNE;
                    rvdec_pkg::F3_BLT:  d.mn = rvdec_pkg::MN_BLT;
                    rvdec_pkg::F3_BGE:  d.mn = rvdec_pkg::MN_BGE;
                    rvdec_pkg::F3_BLTU: d.mn = rvdec_pkg::MN_BLTU;
                    rvdec_pkg::F3_BGEU: d.mn = rvdec_pkg::MN_BGEU;
                    default:            d.mn = rvdec_pkg::MN_UNKNOWN;
                endcase
                if (d.mn != rvdec_pkg::MN_UNKNOWN)
                begin
                    d.fmt = rvdec_pkg::FMT_B;
                    d.imm = {{19{boff[12]}}, boff};
                end
            end
            rvdec_pkg::OPC_JAL:
            begin
                d.mn  = rvdec_pkg::MN_JAL;
                d.fmt = rvdec_pkg::FMT_J;
                d.imm = {{11{joff[20]}}, joff};
            end
            rvdec_pkg::OPC_JALR:
            begin
                if (f3 == rvdec_pkg::F3_JALR)
                begin
                    d.mn  = rvdec_pkg::MN_JALR;
                    d.fmt = rvdec_pkg::FMT_I_LOAD;
                    d.imm = imm_i;
                end
            end
            default:
            begin
                d.mn = rvdec_pkg::MN_UNKNOWN;
            end
        endcase
        return d;
    endfunction

    // Queue predictions on input acceptance, compare on output acceptance
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        decoded_t got;

        if (!rst_n)
        begin
            expected_q.delete();
            kinds_hit       = '0;
            error_count     = 0;
            pending         = 0;
            results_checked = 0;
            kinds_seen      = 0;
            unknown_seen    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{mnemonic, format, dest_reg, src1_reg, src2_reg, immediate};
                if (expected_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result item mn=%0d fmt=%0d imm=%h",
                                 $realtime, mnemonic, format, immediate);
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (want.mn == rvdec_pkg::MN_UNKNOWN)
                        unknown_seen++;
                    else
                        kinds_hit[want.mn] = 1'b1;
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: mismatch on result item %0d", $realtime,
                                     results_checked);
                            $display("    mnemonic exp %0d act %0d, format exp %0d act %0d",
                                     want.mn, got.mn, want.fmt, got.fmt);
                            $display("    rd exp %0d act %0d, rs1 exp %0d act %0d",
                                     want.rd, got.rd, want.rs1, got.rs1);
                            $display("    rs2 exp %0d act %0d", want.rs2, got.rs2);
                            $display("    immediate exp %h act %h", want.imm, got.imm);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_q.push_back(decode_word(instruction));

            pending    = expected_q.size();
            kinds_seen = $countones(kinds_hit[37:1]);
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1600;
    localparam int QUIET_TAIL   = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  mnemonic;
    logic [2:0]  format;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;

    int error_count;
    int pending;
    int results_checked;
    int kinds_seen;
    int unknown_seen;

    logic tx_idle_on;
    logic rx_idle_on;
    int   words_sent;

    rv32i_instruction_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mnemonic    (mnemonic),
        .format      (format),
        .dest_reg    (dest_reg),
        .src1_reg    (src1_reg),
        .src2_reg    (src2_reg),
        .immediate   (immediate)
    );

    rv32i_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .instruction     (instruction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mnemonic        (mnemonic),
        .format          (format),
        .dest_reg        (dest_reg),
        .src1_reg        (src1_reg),
        .src2_reg        (src2_reg),
        .immediate       (immediate),
        .error_count     (error_count),
        .pending         (pending),
        .results_checked (results_checked),
        .kinds_seen      (kinds_seen),
        .unknown_seen    (unknown_seen)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Build a word for the given mnemonic, taking the free bits from fill
    function automatic logic [31:0] encode_op(rvdec_pkg::mnemonic_t m, logic [31:0] fill);
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        has_f3;
        logic        has_f7;

        // Opcode by mnemonic group
        case (m) inside
            rvdec_pkg::MN_LUI:                       opc = rvdec_pkg::OPC_LUI;
            rvdec_pkg::MN_AUIPC:                     opc = rvdec_pkg::OPC_AUIPC;
            [rvdec_pkg::MN_ADDI:rvdec_pkg::MN_SRAI]: opc = rvdec_pkg::OPC_OP_IMM;
            [rvdec_pkg::MN_LB:rvdec_pkg::MN_LHU]:    opc = rvdec_pkg::OPC_LOAD;
            [rvdec_pkg::MN_SB:rvdec_pkg::MN_SW]:     opc = rvdec_pkg::OPC_STORE;
            [rvdec_pkg::MN_BEQ:rvdec_pkg::MN_BGEU]:  opc = rvdec_pkg::OPC_BRANCH;
            rvdec_pkg::MN_JAL:                       opc = rvdec_pkg::OPC_JAL;
            rvdec_pkg::MN_JALR:                      opc = rvdec_pkg::OPC_JALR;
            default:                                 opc = rvdec_pkg::OPC_OP;
        endcase

        // funct3 by mnemonic
        case (m)
            rvdec_pkg::MN_SLL, rvdec_pkg::MN_SLLI:   f3 = rvdec_pkg::F3_SLL;
            rvdec_pkg::MN_SLT, rvdec_pkg::MN_SLTI:   f3 = rvdec_pkg::F3_SLT;
            rvdec_pkg::MN_SLTU, rvdec_pkg::MN_SLTIU: f3 = rvdec_pkg::F3_SLTU;
            rvdec_pkg::MN_XOR, rvdec_pkg::MN_XORI:   f3 = rvdec_pkg::F3_XOR;
            rvdec_pkg::MN_SRL, rvdec_pkg::MN_SRA,
            rvdec_pkg::MN_SRLI, rvdec_pkg::MN_SRAI:  f3 = rvdec_pkg::F3_SR;
            rvdec_pkg::MN_OR, rvdec_pkg::MN_ORI:     f3 = rvdec_pkg::F3_OR;
            rvdec_pkg::MN_AND, rvdec_pkg::MN_ANDI:   f3 = rvdec_pkg::F3_AND;
            rvdec_pkg::MN_LB, rvdec_pkg::MN_SB:      f3 = rvdec_pkg::F3_B;
            rvdec_pkg::MN_LH, rvdec_pkg::MN_SH:      f3 = rvdec_pkg::F3_H;
            rvdec_pkg::MN_LW, rvdec_pkg::MN_SW:      f3 = rvdec_pkg::F3_W;
            rvdec_pkg::MN_LBU:                       f3 = rvdec_pkg::F3_BU;
            rvdec_pkg::MN_LHU:                       f3 = rvdec_pkg::F3_HU;
            rvdec_pkg::MN_BEQ:                       f3 = rvdec_pkg::F3_BEQ;
            rvdec_pkg::MN_BNE:                       f3 = rvdec_pkg::F3_BNE;
            rvdec_pkg::MN_BLT:                       f3 = rvdec_pkg::F3_BLT;
            rvdec_pkg::MN_BGE:                       f3 = rvdec_pkg::F3_BGE;
            rvdec_pkg::MN_BLTU:                      f3 = rvdec_pkg::F3_BLTU;
            rvdec_pkg::MN_BGEU:                      f3 = rvdec_pkg::F3_BGEU;
            rvdec_pkg::MN_JALR:                      f3 = rvdec_pkg::F3_JALR;
            default:                                 f3 = rvdec_pkg::F3_ADD;
        endcase

        // funct7 only where the decoder checks it
        case (m)
            rvdec_pkg::MN_SUB, rvdec_pkg::MN_SRA,
            rvdec_pkg::MN_SRAI:                      f7 = rvdec_pkg::F7_ALT;
            default:                                 f7 = rvdec_pkg::F7_BASE;
        endcase
        has_f3 = !(m inside {rvdec_pkg::MN_LUI, rvdec_pkg::MN_AUIPC, rvdec_pkg::MN_JAL});
        has_f7 = m inside {[rvdec_pkg::MN_ADD:rvdec_pkg::MN_AND], rvdec_pkg::MN_SLLI,
                           rvdec_pkg::MN_SRLI, rvdec_pkg::MN_SRAI};

        w       = fill;
        w[6:0]  = opc;
        if (has_f3)
            w[14:12] = f3;
        if (has_f7)
            w[31:25] = f7;
        return w;
    endfunction

    // Mostly well-formed words, some known opcodes with random functs, some noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [31:0] fill;
        int          pick;

        pick = $urandom_range(0, 99);
        fill = $urandom();
        if ($urandom_range(0, 15) == 0)
            fill = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if (pick < 75)
            return encode_op(rvdec_pkg::mnemonic_t'($urandom_range(1, 37)), fill);
        w = fill;
        if (pick < 90)
        begin
            case ($urandom_range(0, 8))
                0:       w[6:0] = rvdec_pkg::OPC_LUI;
                1:       w[6:0] = rvdec_pkg::OPC_AUIPC;
                2:       w[6:0] = rvdec_pkg::OPC_OP;
                3:       w[6:0] = rvdec_pkg::OPC_OP_IMM;
                4:       w[6:0] = rvdec_pkg::OPC_LOAD;
                5:       w[6:0] = rvdec_pkg::OPC_STORE;
                6:       w[6:0] = rvdec_pkg::OPC_BRANCH;
                7:       w[6:0] = rvdec_pkg::OPC_JAL;
                default: w[6:0] = rvdec_pkg::OPC_JALR;
            endcase
        end
        return w;
    endfunction

    // Present one item and hold it until accepted
    task automatic send_word(input logic [31:0] w);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid    = 1'b1;
        instruction = w;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Drop valid and hold off until every queued result has drained
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
    endtask

    // Output-side stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_stall = 1'b0;
        end
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] w;
        int          mode;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        instruction = '0;
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        words_sent  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every mnemonic, free bits alternately all zero and all one
        for (int m = 1; m <= 37; m++)
            send_word(encode_op(rvdec_pkg::mnemonic_t'(m), m[0] ? 32'hFFFF_FFFF : 32'h0));

        // Unknown words and near misses
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        w = encode_op(rvdec_pkg::MN_JALR, 32'h8000_0000);
        w[14:12] = 3'd1;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_SLLI, 32'hFFFF_FFFF);
        w[31:25] = rvdec_pkg::F7_ALT;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_SRLI, 32'h0);
        w[31:25] = 7'h01;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_ADD, 32'h0);
        w[31:25] = 7'h01;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_SUB, 32'hFFFF_FFFF);
        w[14:12] = rvdec_pkg::F3_SLL;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_LW, 32'h0);
        w[14:12] = 3'd3;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_SW, 32'h0);
        w[14:12] = 3'd3;
        send_word(w);
        w = encode_op(rvdec_pkg::MN_BEQ, 32'h0);
        w[14:12] = 3'd2;
        send_word(w);

        // Sign bit alone on branch and jump offsets, and a full shift amount on srai
        send_word(encode_op(rvdec_pkg::MN_BNE, 32'h8000_0000));
        send_word(encode_op(rvdec_pkg::MN_JAL, 32'h8000_0000));
        send_word(encode_op(rvdec_pkg::MN_SRAI, 32'h01F0_0000));

        drain_results();

        // Random words, idling mode changing every hundred items
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 100 == 0)
            begin
                mode       = $urandom_range(0, 3);
                tx_idle_on = mode[0];
                rx_idle_on = mode[1];
            end
            if (i == RANDOM_WORDS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (i == RANDOM_WORDS / 2)
                drain_results();
            send_word(random_word());
        end

        drain_results();
        repeat (10) @(posedge clk);

        $display("Decoded %0d instruction words: %0d results checked, %0d of 37 mnemonics",
                 words_sent, results_checked, kinds_seen);
        $display("Unrecognized words checked: %0d, mismatches: %0d",
                 unknown_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: rv32i_instruction_decoder.f
hw/rtl/rvdec_pkg.sv
hw/rtl/rvdec_core.sv
hw/rtl/rv32i_instruction_decoder.sv
tb/rv32i_decoder_checker.sv
tb/tb_top.sv
